[rtl/meter_record_value_extractor_core_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the meter record value extractor.
// Each macro checks a property on the rising clock edge, outside reset.
// ---------------------------------------------------------------------------
`ifndef METER_RECORD_VALUE_EXTRACTOR_CORE_ASSERT_SVH
`define METER_RECORD_VALUE_EXTRACTOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define MRVE_ASSERT_HOLDS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("mrve: property failed");
`define MRVE_ASSERT_IMPLIES(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("mrve: implication failed");
`define MRVE_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("mrve: next-cycle implication failed");
`else
`define MRVE_ASSERT_HOLDS(label, cond)
`define MRVE_ASSERT_IMPLIES(label, pre, post)
`define MRVE_ASSERT_NEXT(label, pre, post)
`endif
`endif

[rtl/mrve_pkg.sv]
// ---------------------------------------------------------------------------
// Meter record value extractor package
// Shared types, constants and index classification functions.
// ---------------------------------------------------------------------------
`default_nettype none
package mrve_pkg;

   localparam int MAX_RECORD_BYTES_DEFAULT = 2048;

   localparam logic [15:0] RECORDS_START   = 16'd28;
   localparam logic [15:0] LENGTH_HI_POS   = 16'd12;
   localparam logic [15:0] LENGTH_LO_POS   = 16'd13;
   localparam logic [15:0] POSITION_MAX    = 16'hFFFF;

   localparam logic [7:0] TYPE_MEASUREMENT = 8'd4;
   localparam logic [7:0] TYPE_COUNTER     = 8'd8;
   localparam logic [3:0] SIZE_MEASUREMENT = 4'd8;
   localparam logic [3:0] SIZE_COUNTER     = 4'd12;
   localparam logic [3:0] HEADER_BYTES     = 4'd4;

   localparam logic [7:0]  RESET_WANTED_TYPE     = 8'd4;
   localparam logic [7:0]  RESET_WANTED_INDEX    = 8'd1;
   localparam logic [15:0] RESET_EXPECTED_LENGTH = 16'd588;

   localparam logic [1:0] CSR_WANTED_TYPE     = 2'd0;
   localparam logic [1:0] CSR_WANTED_INDEX    = 2'd1;
   localparam logic [1:0] CSR_EXPECTED_LENGTH = 2'd2;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_LEN   = 2'd1,
      STATUS_NOT_FOUND = 2'd2,
      STATUS_NO_SCALE  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      UNIT_DECIWATT  = 2'd0,
      UNIT_MILLI     = 2'd1,
      UNIT_WATTSEC   = 2'd2
   } unit_type;

   typedef enum logic [1:0] {
      PHASE_SEARCH  = 2'd0,
      PHASE_CAPTURE = 2'd1,
      PHASE_FOUND   = 2'd2,
      PHASE_STOP    = 2'd3
   } phase_type;

   typedef struct packed {
      phase_type   search_phase;
      logic [63:0] value_accum;
      logic [15:0] declared_length;
   } frame_next_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] raw_value;
      logic [1:0]  unit_code;
   } rsp_payload_type;

   function automatic logic is_power_index(input logic [7:0] idx);
      case (idx) inside
         [8'd1:8'd4], 8'd9, 8'd10, [8'd21:8'd24], 8'd29, 8'd30,
         [8'd41:8'd44], 8'd49, 8'd50, [8'd61:8'd64], 8'd69, 8'd70: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic logic is_milli_index(input logic [7:0] idx);
      case (idx) inside
         8'd13, 8'd31, 8'd32, 8'd51, 8'd52, 8'd71, 8'd72: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

endpackage
`default_nettype wire

[rtl/mrve_channels.sv]
// ---------------------------------------------------------------------------
// Meter record value extractor channels
// Request, response and register write channels with valid and ready.
// ---------------------------------------------------------------------------
`default_nettype none
interface mrve_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;
   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mrve_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [63:0] raw_value;
   logic [1:0]  unit_code;
   modport source (output valid, output status, output raw_value, output unit_code,
                   input ready);
   modport sink (input valid, input status, input raw_value, input unit_code,
                 output ready);
endinterface

interface mrve_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[rtl/meter_record_value_extractor_core.sv]
// ---------------------------------------------------------------------------
// Meter record value extractor core
// Walks the records of a meter datagram one byte per request and reports
// the value of the first record of the configured type and index.
// ---------------------------------------------------------------------------
//   Channel  Direction  Carries
//   req_bus  in         data_byte, last_byte
//   rsp_bus  out        status, raw_value, unit_code (one per datagram)
//   csr_bus  in         index, data (register writes, always ready)
//
// One request is taken every cycle; the response of a final byte is held
// in the output register in the cycle after it is accepted.
// A request is refused only while a response waits and rsp_bus.ready is low.
// Synchronous reset restores the register defaults and clears frame state.
// ---------------------------------------------------------------------------
`default_nettype none
`include "meter_record_value_extractor_core_assert.svh"
module meter_record_value_extractor_core
   import mrve_pkg::*;
#(
   parameter int MAX_RECORD_BYTES = MAX_RECORD_BYTES_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   mrve_req_if.sink   req_bus,
   mrve_rsp_if.source rsp_bus,
   mrve_csr_if.sink   csr_bus
);

   logic [7:0]      wanted_type_ff;
   logic [7:0]      wanted_index_ff;
   logic [15:0]     expected_length_ff;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;
   frame_next_type  frame_next;
   logic            req_accept;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wanted_type_ff     <= RESET_WANTED_TYPE;
         wanted_index_ff    <= RESET_WANTED_INDEX;
         expected_length_ff <= RESET_EXPECTED_LENGTH;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_WANTED_TYPE:     wanted_type_ff     <= csr_bus.data[7:0];
            CSR_WANTED_INDEX:    wanted_index_ff    <= csr_bus.data[7:0];
            CSR_EXPECTED_LENGTH: expected_length_ff <= csr_bus.data;
            default: begin
            end
         endcase
      end
   end

   mrve_frame_walker #(
      .MAX_RECORD_BYTES(MAX_RECORD_BYTES)
   ) u_walker (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .data_byte   (req_bus.data_byte),
      .last_byte   (req_bus.last_byte),
      .wanted_type (wanted_type_ff),
      .wanted_index(wanted_index_ff),
      .frame_next  (frame_next)
   );

   mrve_verdict u_verdict (
      .wanted_type    (wanted_type_ff),
      .wanted_index   (wanted_index_ff),
      .expected_length(expected_length_ff),
      .frame_next     (frame_next),
      .result         (rsp_payload_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept && req_bus.last_byte) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (req_accept && req_bus.last_byte) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.status    = rsp_payload_ff.status;
   assign rsp_bus.raw_value = rsp_payload_ff.raw_value;
   assign rsp_bus.unit_code = rsp_payload_ff.unit_code;

   `MRVE_ASSERT_IMPLIES(a_fail_clears_value, rsp_valid_ff && rsp_payload_ff.status != STATUS_OK, rsp_payload_ff.raw_value == 64'd0 && rsp_payload_ff.unit_code == UNIT_DECIWATT)
   `MRVE_ASSERT_NEXT(a_final_gives_response, req_accept && req_bus.last_byte, rsp_valid_ff)
   `MRVE_ASSERT_IMPLIES(a_no_accept_when_full, rsp_valid_ff && !rsp_bus.ready, !req_accept)
   `MRVE_ASSERT_HOLDS(a_unit_in_range, !rsp_valid_ff || rsp_payload_ff.unit_code != 2'd3)

endmodule
`default_nettype wire

[rtl/mrve_frame_walker.sv]
// ---------------------------------------------------------------------------
// Meter record value extractor frame walker
// Tracks the byte position, the declared length and the record chain, and
// captures the value of the first matching record.
// ---------------------------------------------------------------------------
`default_nettype none
module mrve_frame_walker
   import mrve_pkg::*;
#(
   parameter int MAX_RECORD_BYTES = MAX_RECORD_BYTES_DEFAULT
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           accept,
   input  logic [7:0]     data_byte,
   input  logic           last_byte,
   input  logic [7:0]     wanted_type,
   input  logic [7:0]     wanted_index,
   output frame_next_type frame_next
);

   localparam logic [15:0] MaxBytes = 16'(MAX_RECORD_BYTES);

   logic [15:0] byte_position_ff, byte_position_in;
   logic [15:0] declared_length_ff, declared_length_in;
   logic [3:0]  record_offset_ff, record_offset_in;
   logic [3:0]  record_size_ff, record_size_in;
   logic [7:0]  record_index_ff, record_index_in;
   phase_type   search_phase_ff, search_phase_in;
   logic [63:0] value_accum_ff, value_accum_in;
   logic [15:0] area_limit;

   assign area_limit = (declared_length_ff > MaxBytes) ? MaxBytes : declared_length_ff;

   always_comb begin
      logic       halt;
      logic [3:0] offset_next;
      halt               = 1'b0;
      offset_next        = record_offset_ff + 4'd1;
      byte_position_in   = byte_position_ff;
      declared_length_in = declared_length_ff;
      record_offset_in   = record_offset_ff;
      record_size_in     = record_size_ff;
      record_index_in    = record_index_ff;
      search_phase_in    = search_phase_ff;
      value_accum_in     = value_accum_ff;

      if (byte_position_ff == LENGTH_HI_POS) begin
         declared_length_in = {data_byte, declared_length_ff[7:0]};
      end else if (byte_position_ff == LENGTH_LO_POS) begin
         declared_length_in = {declared_length_ff[15:8], data_byte};
      end

      if (byte_position_ff >= RECORDS_START &&
          (search_phase_ff == PHASE_SEARCH || search_phase_ff == PHASE_CAPTURE)) begin
         if (byte_position_ff == POSITION_MAX) begin
            search_phase_in = PHASE_STOP;
         end else if (search_phase_ff == PHASE_SEARCH && record_offset_ff == 4'd0 &&
                      (byte_position_ff - RECORDS_START) >= area_limit) begin
            search_phase_in = PHASE_STOP;
         end else begin
            case (record_offset_ff)
               4'd0, 4'd3: begin
               end
               4'd1: begin
                  record_index_in = data_byte;
               end
               4'd2: begin
                  if (data_byte == wanted_type && record_index_ff == wanted_index) begin
                     search_phase_in = PHASE_CAPTURE;
                     record_size_in  = (wanted_type == TYPE_COUNTER) ? SIZE_COUNTER
                                                                     : SIZE_MEASUREMENT;
                  end else if (data_byte == TYPE_COUNTER) begin
                     record_size_in = SIZE_COUNTER;
                  end else if (data_byte == TYPE_MEASUREMENT) begin
                     record_size_in = SIZE_MEASUREMENT;
                  end else begin
                     search_phase_in = PHASE_STOP;
                     halt            = 1'b1;
                  end
               end
               default: begin
                  if (search_phase_ff == PHASE_CAPTURE) begin
                     value_accum_in = {value_accum_ff[55:0], data_byte};
                  end
               end
            endcase
            if (!halt) begin
               if (offset_next >= HEADER_BYTES && offset_next >= record_size_in) begin
                  if (search_phase_in == PHASE_CAPTURE) begin
                     search_phase_in = PHASE_FOUND;
                  end
                  record_offset_in = 4'd0;
               end else begin
                  record_offset_in = offset_next;
               end
            end
         end
      end

      if (byte_position_ff != POSITION_MAX) begin
         byte_position_in = byte_position_ff + 16'd1;
      end
   end

   assign frame_next.search_phase    = search_phase_in;
   assign frame_next.value_accum     = value_accum_in;
   assign frame_next.declared_length = declared_length_in;

   always_ff @(posedge clock) begin
      if (reset || (accept && last_byte)) begin
         byte_position_ff   <= '0;
         declared_length_ff <= '0;
         record_offset_ff   <= '0;
         record_size_ff     <= '0;
         record_index_ff    <= '0;
         search_phase_ff    <= PHASE_SEARCH;
         value_accum_ff     <= '0;
      end else if (accept) begin
         byte_position_ff   <= byte_position_in;
         declared_length_ff <= declared_length_in;
         record_offset_ff   <= record_offset_in;
         record_size_ff     <= record_size_in;
         record_index_ff    <= record_index_in;
         search_phase_ff    <= search_phase_in;
         value_accum_ff     <= value_accum_in;
      end
   end

endmodule
`default_nettype wire

[rtl/mrve_verdict.sv]
// ---------------------------------------------------------------------------
// Meter record value extractor verdict
// Forms the status, raw value and unit code from the state left by the
// final byte of a datagram.
// ---------------------------------------------------------------------------
`default_nettype none
module mrve_verdict
   import mrve_pkg::*;
(
   input  logic [7:0]      wanted_type,
   input  logic [7:0]      wanted_index,
   input  logic [15:0]     expected_length,
   input  frame_next_type  frame_next,
   output rsp_payload_type result
);

   logic     scaled;
   unit_type unit;

   always_comb begin
      scaled = 1'b0;
      unit   = UNIT_DECIWATT;
      if (wanted_type == TYPE_COUNTER && is_power_index(wanted_index)) begin
         scaled = 1'b1;
         unit   = UNIT_WATTSEC;
      end else if (wanted_type == TYPE_MEASUREMENT && is_power_index(wanted_index)) begin
         scaled = 1'b1;
         unit   = UNIT_DECIWATT;
      end else if (wanted_type == TYPE_MEASUREMENT && is_milli_index(wanted_index)) begin
         scaled = 1'b1;
         unit   = UNIT_MILLI;
      end
   end

   always_comb begin
      result.status    = STATUS_OK;
      result.raw_value = '0;
      result.unit_code = UNIT_DECIWATT;
      if (frame_next.declared_length != expected_length) begin
         result.status = STATUS_BAD_LEN;
      end else if (!scaled) begin
         result.status = STATUS_NO_SCALE;
      end else if (frame_next.search_phase != PHASE_FOUND) begin
         result.status = STATUS_NOT_FOUND;
      end else begin
         result.raw_value = (wanted_type == TYPE_MEASUREMENT)
                            ? {32'd0, frame_next.value_accum[31:0]}
                            : frame_next.value_accum;
         result.unit_code = unit;
      end
   end

endmodule
`default_nettype wire
